// ===== rtl/core/vdcm_pkg.sv =====
// shared types, constants and codes of the virtqueue descriptor chain manager
package vdcm_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int BLOCK_BYTES = 1024;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int STEP_W      = $clog2(QUEUE_DEPTH);

    localparam int ADDR_W      = 64;
    localparam int DESC_W      = 3;
    localparam int LEN_W       = 11;
    localparam int FLAGS_W     = 2;
    localparam int COUNT_W     = 16;
    localparam int ID_W        = 8;
    localparam int SECTOR_BITS = 61;
    localparam int HDR_SHIFT   = 4;

    localparam logic [LEN_W-1:0]   HDR_BYTES    = LEN_W'(16);
    localparam logic [LEN_W-1:0]   DATA_BYTES   = LEN_W'(BLOCK_BYTES);
    localparam logic [LEN_W-1:0]   STATUS_BYTES = LEN_W'(1);
    localparam logic [FLAGS_W-1:0] FLAG_NEXT    = 2'b01;
    localparam logic [FLAGS_W-1:0] FLAG_DEVW    = 2'b10;

    typedef enum logic {
        CMD_SUBMIT   = 1'b0,
        CMD_COMPLETE = 1'b1
    } t_cmd;

    typedef enum logic {
        CFG_HEADER_BASE = 1'b0,
        CFG_STATUS_BASE = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        KIND_DESC_WRITE    = 3'd0,
        KIND_AVAIL_PUBLISH = 3'd1,
        KIND_POOL_FULL     = 3'd2,
        KIND_SECTOR_OVF    = 3'd3,
        KIND_DONE          = 3'd4,
        KIND_BAD_ID        = 3'd5,
        KIND_NOT_IN_FLIGHT = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DATA,
        ST_STATUS,
        ST_PUBLISH,
        ST_WALK
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REJECT,
        OP_ALLOC,
        OP_DATA,
        OP_STATUS,
        OP_PUBLISH,
        OP_WALK_START,
        OP_WALK_STEP,
        OP_WALK_LAST
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        t_kind  kind;
    } t_dp_cmd;

    typedef struct packed {
        logic is_submit;
        logic overflow;
        logic pool_short;
        logic bad_id;
        logic not_in_flight;
        logic walk_end;
    } t_dp_sts;

endpackage

// ===== rtl/core/vdcm_ctrl.sv =====
// controller state machine sequencing submits and completions
module vdcm_ctrl import vdcm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_sts.is_submit) begin
                    n_state = (i_sts.overflow || i_sts.pool_short) ? ST_IDLE : ST_DATA;
                end else begin
                    n_state = (i_sts.bad_id || i_sts.not_in_flight) ? ST_IDLE : ST_WALK;
                end
            end
            ST_DATA:    n_state = ST_STATUS;
            ST_STATUS:  n_state = ST_PUBLISH;
            ST_PUBLISH: n_state = ST_IDLE;
            ST_WALK: begin
                if (i_sts.walk_end) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.kind = KIND_DONE;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            ST_DECIDE: begin
                if (i_sts.is_submit) begin
                    if (i_sts.overflow) begin
                        o_cmd.op   = OP_REJECT;
                        o_cmd.kind = KIND_SECTOR_OVF;
                    end else if (i_sts.pool_short) begin
                        o_cmd.op   = OP_REJECT;
                        o_cmd.kind = KIND_POOL_FULL;
                    end else begin
                        o_cmd.op = OP_ALLOC;
                    end
                end else begin
                    if (i_sts.bad_id) begin
                        o_cmd.op   = OP_REJECT;
                        o_cmd.kind = KIND_BAD_ID;
                    end else if (i_sts.not_in_flight) begin
                        o_cmd.op   = OP_REJECT;
                        o_cmd.kind = KIND_NOT_IN_FLIGHT;
                    end else begin
                        o_cmd.op = OP_WALK_START;
                    end
                end
            end
            ST_DATA:    o_cmd.op = OP_DATA;
            ST_STATUS:  o_cmd.op = OP_STATUS;
            ST_PUBLISH: o_cmd.op = OP_PUBLISH;
            ST_WALK:    o_cmd.op = i_sts.walk_end ? OP_WALK_LAST : OP_WALK_STEP;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/core/vdcm_datapath.sv =====
// descriptor pool state, base registers, free search and result register
module vdcm_datapath import vdcm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd_dp,
    output t_dp_sts             o_sts,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [ADDR_W-1:0]   i_cfg_data,
    input  logic                i_cmd,
    input  logic [ADDR_W-1:0]   i_block_number,
    input  logic [ADDR_W-1:0]   i_data_address,
    input  logic                i_is_write,
    input  logic [ID_W-1:0]     i_used_id,
    output logic                o_strobe,
    output logic [2:0]          o_kind,
    output logic [DESC_W-1:0]   o_desc_index,
    output logic [ADDR_W-1:0]   o_buf_addr,
    output logic [LEN_W-1:0]    o_buf_len,
    output logic [FLAGS_W-1:0]  o_desc_flags,
    output logic [DESC_W-1:0]   o_next_index,
    output logic [DESC_W-1:0]   o_avail_slot,
    output logic [COUNT_W-1:0]  o_avail_count,
    output logic [ADDR_W-1:0]   o_sector,
    output logic                o_last
);

    // configuration
    logic [ADDR_W-1:0] r_header_base;
    logic [ADDR_W-1:0] r_status_base;

    // latched request word
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_blk;
    logic [ADDR_W-1:0] r_data;
    logic              r_wr;
    logic [ID_W-1:0]   r_id;

    // pool state
    logic              r_free      [QUEUE_DEPTH];
    logic              r_in_flight [QUEUE_DEPTH];
    logic [IDX_W-1:0]  r_next_link [QUEUE_DEPTH];
    logic              r_has_next  [QUEUE_DEPTH];
    logic [COUNT_W-1:0] r_avail;

    // chain picks and walk pointer
    logic [IDX_W-1:0]  r_a;
    logic [IDX_W-1:0]  r_b;
    logic [IDX_W-1:0]  r_c;
    logic [IDX_W-1:0]  r_cur;
    logic [STEP_W-1:0] r_steps;

    logic [IDX_W-1:0]  pick [3];
    logic [1:0]        n_found;
    logic [IDX_W-1:0]  id_idx;
    logic [IDX_W-1:0]  cur_next;
    logic [ADDR_W-1:0] sector;

    // result register
    logic               r_strobe;
    t_kind              r_kind;
    logic [DESC_W-1:0]  r_desc_index;
    logic [ADDR_W-1:0]  r_buf_addr;
    logic [LEN_W-1:0]   r_buf_len;
    logic [FLAGS_W-1:0] r_desc_flags;
    logic [DESC_W-1:0]  r_next_index;
    logic [DESC_W-1:0]  r_avail_slot;
    logic [COUNT_W-1:0] r_avail_count;
    logic [ADDR_W-1:0]  r_sector;
    logic               r_last;

    logic               n_strobe;
    t_kind              n_kind;
    logic [DESC_W-1:0]  n_desc_index;
    logic [ADDR_W-1:0]  n_buf_addr;
    logic [LEN_W-1:0]   n_buf_len;
    logic [FLAGS_W-1:0] n_desc_flags;
    logic [DESC_W-1:0]  n_next_index;
    logic [DESC_W-1:0]  n_avail_slot;
    logic [COUNT_W-1:0] n_avail_count;
    logic [ADDR_W-1:0]  n_sector;
    logic               n_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_base <= '0;
            r_status_base <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_HEADER_BASE: r_header_base <= i_cfg_data;
                CFG_STATUS_BASE: r_status_base <= i_cfg_data;
                default:         r_header_base <= r_header_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.op == OP_LOAD) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_blk  <= i_block_number;
            r_data <= i_data_address;
            r_wr   <= i_is_write;
            r_id   <= i_used_id;
        end
    end

    // lowest three free descriptors, scanned in index order
    always_comb begin
        n_found = '0;
        pick[0] = '0;
        pick[1] = '0;
        pick[2] = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (r_free[i] && n_found != 2'd3) begin
                pick[n_found] = IDX_W'(i);
                n_found       = n_found + 2'd1;
            end
        end
    end

    assign id_idx   = r_id[IDX_W-1:0];
    assign cur_next = r_next_link[r_cur];
    assign sector   = {r_blk[ADDR_W-2:0], 1'b0};

    always_comb begin
        o_sts.is_submit     = (r_cmd == CMD_SUBMIT);
        o_sts.overflow      = &r_blk[SECTOR_BITS-1:0];
        o_sts.pool_short    = (n_found != 2'd3);
        o_sts.bad_id        = ({1'b0, r_id} >= (ID_W+1)'(QUEUE_DEPTH));
        o_sts.not_in_flight = !r_in_flight[id_idx];
        o_sts.walk_end      = !r_has_next[r_cur]
                            || ({1'b0, cur_next} >= (IDX_W+1)'(QUEUE_DEPTH))
                            || (r_steps == STEP_W'(QUEUE_DEPTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_free[i]      <= 1'b1;
                r_in_flight[i] <= 1'b0;
            end
            r_avail <= '0;
        end else begin
            case (i_cmd_dp.op)
                OP_ALLOC: begin
                    r_free[pick[0]]      <= 1'b0;
                    r_free[pick[1]]      <= 1'b0;
                    r_free[pick[2]]      <= 1'b0;
                    r_in_flight[pick[0]] <= 1'b1;
                end
                OP_WALK_START: r_in_flight[id_idx] <= 1'b0;
                OP_WALK_STEP,
                OP_WALK_LAST:  r_free[r_cur] <= 1'b1;
                OP_PUBLISH:    r_avail <= r_avail + COUNT_W'(1);
                default:       r_avail <= r_avail;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd_dp.op)
            OP_ALLOC: begin
                r_a                  <= pick[0];
                r_b                  <= pick[1];
                r_c                  <= pick[2];
                r_next_link[pick[0]] <= pick[1];
                r_has_next[pick[0]]  <= 1'b1;
                r_next_link[pick[1]] <= pick[2];
                r_has_next[pick[1]]  <= 1'b1;
                r_next_link[pick[2]] <= '0;
                r_has_next[pick[2]]  <= 1'b0;
            end
            OP_WALK_START: begin
                r_cur   <= id_idx;
                r_steps <= '0;
            end
            OP_WALK_STEP: begin
                r_cur   <= cur_next;
                r_steps <= r_steps + STEP_W'(1);
            end
            default: r_cur <= r_cur;
        endcase
    end

    always_comb begin
        n_strobe      = 1'b0;
        n_kind        = KIND_DESC_WRITE;
        n_desc_index  = '0;
        n_buf_addr    = '0;
        n_buf_len     = '0;
        n_desc_flags  = '0;
        n_next_index  = '0;
        n_avail_slot  = '0;
        n_avail_count = '0;
        n_sector      = (r_cmd == CMD_SUBMIT) ? sector : '0;
        n_last        = 1'b0;
        case (i_cmd_dp.op)
            OP_REJECT: begin
                n_strobe = 1'b1;
                n_kind   = i_cmd_dp.kind;
                n_last   = 1'b1;
                if (r_cmd == CMD_COMPLETE) begin
                    n_desc_index = r_id[DESC_W-1:0];
                end
            end
            OP_ALLOC: begin
                n_strobe     = 1'b1;
                n_desc_index = DESC_W'(pick[0]);
                n_buf_addr   = r_header_base + (ADDR_W'(pick[0]) << HDR_SHIFT);
                n_buf_len    = HDR_BYTES;
                n_desc_flags = FLAG_NEXT;
                n_next_index = DESC_W'(pick[1]);
            end
            OP_DATA: begin
                n_strobe     = 1'b1;
                n_desc_index = DESC_W'(r_b);
                n_buf_addr   = r_data;
                n_buf_len    = DATA_BYTES;
                n_desc_flags = r_wr ? FLAG_NEXT : (FLAG_NEXT | FLAG_DEVW);
                n_next_index = DESC_W'(r_c);
            end
            OP_STATUS: begin
                n_strobe     = 1'b1;
                n_desc_index = DESC_W'(r_c);
                n_buf_addr   = r_status_base + ADDR_W'(r_a);
                n_buf_len    = STATUS_BYTES;
                n_desc_flags = FLAG_DEVW;
            end
            OP_PUBLISH: begin
                n_strobe      = 1'b1;
                n_kind        = KIND_AVAIL_PUBLISH;
                n_desc_index  = DESC_W'(r_a);
                // depth is a power of two, so the ring slot is the low bits
                n_avail_slot  = DESC_W'(r_avail % QUEUE_DEPTH);
                n_avail_count = r_avail + COUNT_W'(1);
                n_last        = 1'b1;
            end
            OP_WALK_LAST: begin
                n_strobe     = 1'b1;
                n_kind       = KIND_DONE;
                n_desc_index = r_id[DESC_W-1:0];
                n_last       = 1'b1;
            end
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_strobe) begin
            r_kind        <= n_kind;
            r_desc_index  <= n_desc_index;
            r_buf_addr    <= n_buf_addr;
            r_buf_len     <= n_buf_len;
            r_desc_flags  <= n_desc_flags;
            r_next_index  <= n_next_index;
            r_avail_slot  <= n_avail_slot;
            r_avail_count <= n_avail_count;
            r_sector      <= n_sector;
            r_last        <= n_last;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_kind        = r_kind;
    assign o_desc_index  = r_desc_index;
    assign o_buf_addr    = r_buf_addr;
    assign o_buf_len     = r_buf_len;
    assign o_desc_flags  = r_desc_flags;
    assign o_next_index  = r_next_index;
    assign o_avail_slot  = r_avail_slot;
    assign o_avail_count = r_avail_count;
    assign o_sector      = r_sector;
    assign o_last        = r_last;

endmodule

// ===== rtl/core/virtqueue_descriptor_chain_manager.sv =====
// top level of the virtqueue descriptor chain manager
// usage:
// - a request word is taken when start is high and busy is low; busy stays high
//   while the word is worked on, one word at a time
// - submit: the three lowest free descriptors are chained; results come one per
//   cycle as header, data and status descriptor writes, then the avail publish,
//   the header after the decide state and the result register; busy clears with
//   the publish, and the next word can be taken from then on
// - completion: the chain is freed one link per cycle; done follows the last
//   link from the result register, busy clears with it and the next word can come
// - a rejected word (sector overflow, pool full, bad id, not in flight) gives a
//   single result after the decide state and the result register; busy clears
//   with it, so the next word can come from then on
// - each result is on the o_ ports for one cycle with o_strobe high; the receiver
//   cannot stall, and o_last marks the final result of a word
// - config words (header and status base) are always taken; write them only
//   while the block is idle
// - synchronous reset frees every descriptor, clears in-flight marks, the avail
//   index and both base registers
module virtqueue_descriptor_chain_manager import vdcm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [ADDR_W-1:0]   i_cfg_data,
    input  logic                i_cmd,
    input  logic [ADDR_W-1:0]   i_block_number,
    input  logic [ADDR_W-1:0]   i_data_address,
    input  logic                i_is_write,
    input  logic [ID_W-1:0]     i_used_id,
    output logic                o_strobe,
    output logic [2:0]          o_kind,
    output logic [DESC_W-1:0]   o_desc_index,
    output logic [ADDR_W-1:0]   o_buf_addr,
    output logic [LEN_W-1:0]    o_buf_len,
    output logic [FLAGS_W-1:0]  o_desc_flags,
    output logic [DESC_W-1:0]   o_next_index,
    output logic [DESC_W-1:0]   o_avail_slot,
    output logic [COUNT_W-1:0]  o_avail_count,
    output logic [ADDR_W-1:0]   o_sector,
    output logic                o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    vdcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    vdcm_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_dp       (dp_cmd),
        .o_sts          (dp_sts),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_block_number (i_block_number),
        .i_data_address (i_data_address),
        .i_is_write     (i_is_write),
        .i_used_id      (i_used_id),
        .o_strobe       (o_strobe),
        .o_kind         (o_kind),
        .o_desc_index   (o_desc_index),
        .o_buf_addr     (o_buf_addr),
        .o_buf_len      (o_buf_len),
        .o_desc_flags   (o_desc_flags),
        .o_next_index   (o_next_index),
        .o_avail_slot   (o_avail_slot),
        .o_avail_count  (o_avail_count),
        .o_sector       (o_sector),
        .o_last         (o_last)
    );

endmodule

// ===== rtl/core/vdcm_checker.sv =====
// port-level checker for the virtqueue descriptor chain manager, bound to the top
module vdcm_checker import vdcm_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                busy,
    input logic                o_strobe,
    input logic [2:0]          o_kind,
    input logic                o_last
);

    // results only come out of work started earlier
    a_no_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !$past(busy)) |-> !o_strobe)
        else $error("result word while idle");

    // descriptor writes never end a word, every other kind does
    a_last_by_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last == (o_kind != KIND_DESC_WRITE)))
        else $error("last flag does not match result kind");

    // a publish follows directly on a descriptor write
    a_publish_after_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == KIND_AVAIL_PUBLISH)
            |-> ($past(o_strobe) && $past(o_kind) == KIND_DESC_WRITE))
        else $error("publish without preceding descriptor write");

    // a descriptor write is followed at once by another result of the same word
    a_desc_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == KIND_DESC_WRITE) |=> o_strobe)
        else $error("submit results broken off");

endmodule

bind virtqueue_descriptor_chain_manager vdcm_checker u_vdcm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_kind   (o_kind),
    .o_last   (o_last)
);

// ===== sim/tb_virtqueue_descriptor_chain_manager.sv =====
// self-checking testbench of the virtqueue descriptor chain manager
module tb_virtqueue_descriptor_chain_manager;
    import vdcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // longest quiet stretch of a correct run comes from sender gaps, a submit and
    // the settle pause; this limit is many times that
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 100;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] blk;
        logic [ADDR_W-1:0] data;
        logic              wr;
        logic [ID_W-1:0]   id;
    } t_req;

    typedef struct packed {
        t_kind              kind;
        logic [DESC_W-1:0]  desc;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   len;
        logic [FLAGS_W-1:0] flags;
        logic [DESC_W-1:0]  nxt;
        logic [DESC_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0]  sector;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [QUEUE_DEPTH-1:0]             free_map;
        logic [QUEUE_DEPTH-1:0]             in_flight;
        logic [QUEUE_DEPTH-1:0]             has_next;
        logic [QUEUE_DEPTH-1:0][DESC_W-1:0] next_link;
        logic [COUNT_W-1:0]                 avail_idx;
    } t_pool;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [ADDR_W-1:0]  i_cfg_data;
    logic               i_cmd;
    logic [ADDR_W-1:0]  i_block_number;
    logic [ADDR_W-1:0]  i_data_address;
    logic               i_is_write;
    logic [ID_W-1:0]    i_used_id;
    logic               o_strobe;
    logic [2:0]         o_kind;
    logic [DESC_W-1:0]  o_desc_index;
    logic [ADDR_W-1:0]  o_buf_addr;
    logic [LEN_W-1:0]   o_buf_len;
    logic [FLAGS_W-1:0] o_desc_flags;
    logic [DESC_W-1:0]  o_next_index;
    logic [DESC_W-1:0]  o_avail_slot;
    logic [COUNT_W-1:0] o_avail_count;
    logic [ADDR_W-1:0]  o_sector;
    logic               o_last;

    virtqueue_descriptor_chain_manager dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_block_number (i_block_number),
        .i_data_address (i_data_address),
        .i_is_write     (i_is_write),
        .i_used_id      (i_used_id),
        .o_strobe       (o_strobe),
        .o_kind         (o_kind),
        .o_desc_index   (o_desc_index),
        .o_buf_addr     (o_buf_addr),
        .o_buf_len      (o_buf_len),
        .o_desc_flags   (o_desc_flags),
        .o_next_index   (o_next_index),
        .o_avail_slot   (o_avail_slot),
        .o_avail_count  (o_avail_count),
        .o_sector       (o_sector),
        .o_last         (o_last)
    );

    t_req        req_backlog[$];
    t_result     due_results[$];
    t_pool       dut_pool;
    t_pool       plan_pool;
    logic [63:0] header_base;
    logic [63:0] status_base;
    int          idle_pct;
    int          n_queued;
    int          n_taken;
    int          n_submits;
    int          n_completes;
    int          n_checked;
    int          n_cfg_writes;
    int          mismatches;
    int          quiet;
    t_req        cur_req;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_pool pool_after_reset();
        t_pool p;
        p = '0;
        p.free_map = '1;
        return p;
    endfunction

    // outcome of one request word on a pool; updates the pool in place
    function automatic void chain_outcome(inout t_pool p, input t_req r,
                                          input logic [63:0] hb, input logic [63:0] sb,
                                          output t_result [3:0] res, output int n);
        logic [ADDR_W-1:0]  sec;
        logic [DESC_W-1:0]  pick [0:2];
        logic [DESC_W-1:0]  a, b, c, cur;
        logic [FLAGS_W-1:0] dflags;
        int                 found;
        res   = '0;
        n     = 1;
        found = 0;
        sec   = r.blk << 1;
        res[0].last = 1'b1;
        if (r.cmd == CMD_SUBMIT) begin
            res[0].sector = sec;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (p.free_map[i] && found < 3) begin
                    pick[found] = DESC_W'(i);
                    found++;
                end
            end
            if (&r.blk[SECTOR_BITS-1:0]) begin
                res[0].kind = KIND_SECTOR_OVF;
            end else if (found < 3) begin
                res[0].kind = KIND_POOL_FULL;
            end else begin
                a = pick[0];
                b = pick[1];
                c = pick[2];
                p.free_map[a] = 1'b0;
                p.free_map[b] = 1'b0;
                p.free_map[c] = 1'b0;
                p.next_link[a] = b;
                p.has_next[a]  = 1'b1;
                p.next_link[b] = c;
                p.has_next[b]  = 1'b1;
                p.next_link[c] = '0;
                p.has_next[c]  = 1'b0;
                p.in_flight[a] = 1'b1;
                dflags = (r.wr ? FLAGS_W'(0) : FLAG_DEVW) | FLAG_NEXT;
                for (int k = 0; k < 4; k++) begin
                    res[k].sector = sec;
                    res[k].kind   = KIND_DESC_WRITE;
                end
                res[0].desc  = a;
                res[0].addr  = hb + (64'(a) << HDR_SHIFT);
                res[0].len   = HDR_BYTES;
                res[0].flags = FLAG_NEXT;
                res[0].nxt   = b;
                res[0].last  = 1'b0;
                res[1].desc  = b;
                res[1].addr  = r.data;
                res[1].len   = DATA_BYTES;
                res[1].flags = dflags;
                res[1].nxt   = c;
                res[2].desc  = c;
                res[2].addr  = sb + 64'(a);
                res[2].len   = STATUS_BYTES;
                res[2].flags = FLAG_DEVW;
                res[3].kind  = KIND_AVAIL_PUBLISH;
                res[3].desc  = a;
                res[3].slot  = p.avail_idx[DESC_W-1:0];
                p.avail_idx  = p.avail_idx + 1'b1;
                res[3].count = p.avail_idx;
                res[3].last  = 1'b1;
                n = 4;
            end
        end else begin
            res[0].desc = r.id[DESC_W-1:0];
            if (r.id >= QUEUE_DEPTH) begin
                res[0].kind = KIND_BAD_ID;
            end else if (!p.in_flight[r.id[IDX_W-1:0]]) begin
                res[0].kind = KIND_NOT_IN_FLIGHT;
            end else begin
                res[0].kind = KIND_DONE;
                p.in_flight[r.id[IDX_W-1:0]] = 1'b0;
                cur = r.id[DESC_W-1:0];
                for (int s = 0; s < QUEUE_DEPTH; s++) begin
                    p.free_map[cur] = 1'b1;
                    if (!p.has_next[cur]) break;
                    cur = p.next_link[cur];
                end
            end
        end
    endfunction

    function automatic t_req make_req(t_cmd c, logic [63:0] blk, logic [63:0] data,
                                      logic wr, logic [ID_W-1:0] id);
        t_req r;
        r.cmd  = c;
        r.blk  = blk;
        r.data = data;
        r.wr   = wr;
        r.id   = id;
        return r;
    endfunction

    function automatic t_req rand_req();
        return make_req(t_cmd'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom},
                        1'($urandom_range(1)), ID_W'($urandom_range(255)));
    endfunction

    // queue a word and track the pool it will leave behind, so that later
    // completions can aim at chains that are really in flight
    task automatic queue_req(t_req r);
        t_result [3:0] scratch;
        int            cnt;
        chain_outcome(plan_pool, r, '0, '0, scratch, cnt);
        req_backlog.push_back(r);
        n_queued++;
    endtask

    task automatic queue_random(int count);
        t_req r;
        int   roll;
        int   heads[$];
        for (int k = 0; k < count; k++) begin
            r = rand_req();
            roll = $urandom_range(99);
            heads.delete();
            for (int i = 0; i < QUEUE_DEPTH; i++)
                if (plan_pool.in_flight[i]) heads.push_back(i);
            if (roll < 40 && heads.size() != 0) begin
                r.cmd = CMD_COMPLETE;
                r.id  = ID_W'(heads[$urandom_range(heads.size() - 1)]);
            end else if (roll < 80) begin
                r.cmd = CMD_SUBMIT;
                if (&r.blk[SECTOR_BITS-1:0]) r.blk[0] = 1'b0;
            end else if (roll < 87) begin
                r.cmd = CMD_COMPLETE;
                r.id  = ID_W'($urandom_range(255, QUEUE_DEPTH));
            end else if (roll < 93) begin
                r.cmd = CMD_COMPLETE;
                r.id  = ID_W'($urandom_range(QUEUE_DEPTH - 1));
            end else begin
                r.cmd = CMD_SUBMIT;
                r.blk[SECTOR_BITS-1:0] = '1;
            end
            queue_req(r);
        end
    endtask

    // wait until every queued word is taken and answered, then let the walk settle
    task automatic wait_quiet();
        do @(posedge i_clk); while (n_taken != n_queued || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_index idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_HEADER_BASE) header_base = val;
        else status_base = val;
        n_cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(logic [63:0] hb, logic [63:0] sb, int pct);
        write_cfg(CFG_HEADER_BASE, hb);
        write_cfg(CFG_STATUS_BASE, sb);
        idle_pct = pct;
        queue_random(RANDOM_ITEMS);
        wait_quiet();
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    // driver: presents backlog words on the request ports, predicts at accept
    always @(posedge i_clk) begin : driver
        t_result [3:0] res;
        int            cnt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                chain_outcome(dut_pool, cur_req, header_base, status_base, res, cnt);
                for (int k = 0; k < cnt; k++) due_results.push_back(res[k]);
                if (cur_req.cmd == CMD_SUBMIT) n_submits++;
                else n_completes++;
                n_taken++;
            end
            if (!start || !busy) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_req = req_backlog.pop_front();
                    i_cmd          <= cur_req.cmd;
                    i_block_number <= cur_req.blk;
                    i_data_address <= cur_req.data;
                    i_is_write     <= cur_req.wr;
                    i_used_id      <= cur_req.id;
                    start          <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed word is checked against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (due_results.size() == 0) begin
                $error("result with nothing pending: kind %0d desc %0d", o_kind, o_desc_index);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("kind", 64'(want.kind), 64'(o_kind));
                check_field("desc_index", 64'(want.desc), 64'(o_desc_index));
                check_field("buf_addr", want.addr, o_buf_addr);
                check_field("buf_len", 64'(want.len), 64'(o_buf_len));
                check_field("desc_flags", 64'(want.flags), 64'(o_desc_flags));
                check_field("next_index", 64'(want.nxt), 64'(o_next_index));
                check_field("avail_slot", 64'(want.slot), 64'(o_avail_slot));
                check_field("avail_count", 64'(want.count), 64'(o_avail_count));
                check_field("sector", want.sector, o_sector);
                check_field("last", 64'(want.last), 64'(o_last));
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("timeout: %0d cycles without a word moving", quiet);
            $display("** virtqueue_descriptor_chain_manager: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= 1'b0;
        i_cfg_data     <= '0;
        i_cmd          <= 1'b0;
        i_block_number <= '0;
        i_data_address <= '0;
        i_is_write     <= 1'b0;
        i_used_id      <= '0;
        quiet          <= 0;
        dut_pool     = pool_after_reset();
        plan_pool    = pool_after_reset();
        header_base  = '0;
        status_base  = '0;
        idle_pct     = 0;
        n_queued     = 0;
        n_taken      = 0;
        n_submits    = 0;
        n_completes  = 0;
        n_checked    = 0;
        n_cfg_writes = 0;
        mismatches   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, both overflow patterns, pool full, every reject
        queue_req(make_req(CMD_SUBMIT, '0, '0, 1'b0, '0));
        queue_req(make_req(CMD_SUBMIT, '1, '1, 1'b1, '1));
        queue_req(make_req(CMD_SUBMIT, 64'h1fff_ffff_ffff_ffff, '0, 1'b0, '0));
        queue_req(make_req(CMD_SUBMIT, 64'h1fff_ffff_ffff_fffe, '1, 1'b1, '1));
        queue_req(make_req(CMD_SUBMIT, 64'he000_0000_0000_0000, '0, 1'b0, '0));
        queue_req(make_req(CMD_COMPLETE, '1, '1, 1'b1, 8'hff));
        queue_req(make_req(CMD_COMPLETE, '0, '0, 1'b0, 8'd8));
        queue_req(make_req(CMD_COMPLETE, '0, '0, 1'b0, 8'd1));
        queue_req(make_req(CMD_COMPLETE, '0, '0, 1'b0, 8'd7));
        queue_req(make_req(CMD_COMPLETE, '0, '0, 1'b0, 8'd0));
        queue_req(make_req(CMD_COMPLETE, '0, '0, 1'b0, 8'd0));
        queue_req(make_req(CMD_SUBMIT, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
                           1'b0, 8'h80));
        queue_req(make_req(CMD_COMPLETE, '0, '0, 1'b0, 8'd3));
        queue_req(make_req(CMD_SUBMIT, 64'd1, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 8'h7f));
        queue_req(make_req(CMD_SUBMIT, 64'h0fff_ffff_ffff_ffff, '0, 1'b1, '0));
        queue_req(make_req(CMD_COMPLETE, '0, '0, 1'b0, 8'd3));
        queue_req(make_req(CMD_COMPLETE, '0, '0, 1'b0, 8'd0));
        queue_req(make_req(CMD_COMPLETE, '0, '0, 1'b0, 8'd6));
        wait_quiet();

        run_phase('1, '1, 0);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 78);
        run_phase('0, '0, 0);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 30);

        $display("run: %0d submit and %0d completion words, %0d result words checked",
                 n_submits, n_completes, n_checked);
        $display("     %0d base register writes, sender gaps of 0/78/30 in 100",
                 n_cfg_writes);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("** virtqueue_descriptor_chain_manager: PASSED **");
        end else begin
            $display("** virtqueue_descriptor_chain_manager: FAILED **");
        end
        $finish;
    end

endmodule
